// ===== hdl/bitmap_sector_allocator_macros.svh =====
// Assertion macros shared by the allocator RTL.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef BITMAP_SECTOR_ALLOCATOR_MACROS_SVH
`define BITMAP_SECTOR_ALLOCATOR_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define BSA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define BSA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/bsa_pkg.sv =====
package bsa_pkg;

  localparam int FILE_ID_W = 4;
  localparam int COUNT_W   = 8;

  localparam logic CMD_CREATE = 1'b0;
  localparam logic CMD_DELETE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EXISTS    = 2'd1,
    ST_NO_SPACE  = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef struct packed {
    logic                 used;
    logic [FILE_ID_W-1:0] owner;
  } sector_entry_t;

endpackage

// ===== hdl/bsa_sector_ram.sv =====
module bsa_sector_ram import bsa_pkg::*; #(
  parameter int DEPTH = 128,
  parameter int AW    = 7
) (
  input  logic          clk_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  sector_entry_t wr_entry_i,
  input  logic [AW-1:0] rd_addr_i,
  output sector_entry_t rd_entry_o
);

  sector_entry_t mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_entry_o <= mem[rd_addr_i];
  end

endmodule

// ===== hdl/bitmap_sector_allocator.sv =====
// An accepted create or delete walks the sector table one entry per cycle (S_SCAN), then
// updates the free count and file valid bit (S_FIN) and registers its result (S_DONE);
// a rejected item goes straight to S_DONE. No new input beat is taken until the result is
// registered at the output, and a result beat held by out_stall_i holds the block too.
// Reset: rst_ni clears control state, then a pass over every sector writes the table
// (reserved sectors marked used) while no input beat is taken.
module bitmap_sector_allocator import bsa_pkg::*; #(
  parameter int SECTORS   = 128,
  parameter int RESERVED  = 16,
  parameter int MAX_FILES = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 cmd_i,
  input  logic [FILE_ID_W-1:0] file_id_i,
  input  logic [COUNT_W-1:0]   sector_count_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [1:0]           status_o,
  output logic [COUNT_W-1:0]   granted_count_o,
  output logic [COUNT_W-1:0]   free_count_o
);

`include "bitmap_sector_allocator_macros.svh"

  localparam int AW        = $clog2(SECTORS);
  localparam int CW        = $clog2(SECTORS + 1);
  localparam int CMP_W     = (CW > COUNT_W) ? CW : COUNT_W;
  localparam int IDX_W     = $clog2(MAX_FILES);
  localparam int RED_STEPS = ((2 ** FILE_ID_W) - 1) / MAX_FILES;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_SCAN,
    S_FIN,
    S_DONE
  } state_e;

  state_e                 state_q;
  logic [AW-1:0]          idx_q;
  logic                   cmd_q;
  logic [FILE_ID_W-1:0]   fid_q;
  logic [COUNT_W-1:0]     want_q;
  logic [CW-1:0]          granted_q;
  status_e                status_q;
  logic [CW-1:0]          free_q;
  logic [MAX_FILES-1:0]   file_valid_q;
  logic                   out_valid_q;
  status_e                status_out_q;
  logic [COUNT_W-1:0]     granted_out_q;
  logic [COUNT_W-1:0]     free_out_q;

  logic [FILE_ID_W-1:0]   fid_in;
  logic [IDX_W-1:0]       fidx_in;
  logic [IDX_W-1:0]       fidx_q;
  logic                   in_accept;
  logic                   out_free;
  logic                   last_idx;
  logic                   claim;
  logic                   free_hit;
  logic [AW-1:0]          rd_addr;
  logic                   wr_en;
  sector_entry_t          wr_entry;
  sector_entry_t          rd_entry;

  // The file id wraps modulo MAX_FILES by repeated subtraction.
  always_comb begin
    fid_in = file_id_i;
    for (int k = 0; k < RED_STEPS; k++) begin
      if (32'(fid_in) >= MAX_FILES) begin
        fid_in = fid_in - FILE_ID_W'(MAX_FILES);
      end
    end
  end

  assign fidx_in   = IDX_W'(fid_in);
  assign fidx_q    = IDX_W'(fid_q);
  assign in_accept = in_valid_i && (state_q == S_IDLE);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign last_idx  = (idx_q == AW'(SECTORS - 1));

  always_comb begin
    rd_addr  = '0;
    wr_en    = 1'b0;
    wr_entry = '{used: 1'b0, owner: '0};
    claim    = 1'b0;
    free_hit = 1'b0;
    case (state_q)
      S_INIT: begin
        wr_en         = 1'b1;
        wr_entry.used = (32'(idx_q) < RESERVED);
      end
      S_SCAN: begin
        rd_addr = idx_q + AW'(1);
        if (cmd_q == CMD_CREATE) begin
          claim    = !rd_entry.used && (CMP_W'(granted_q) < CMP_W'(want_q));
          wr_en    = claim;
          wr_entry = '{used: 1'b1, owner: fid_q};
        end else begin
          free_hit = (32'(idx_q) >= RESERVED) && rd_entry.used && (rd_entry.owner == fid_q);
          wr_en    = free_hit;
          wr_entry = '{used: 1'b0, owner: rd_entry.owner};
        end
      end
      default: ;
    endcase
  end

  bsa_sector_ram #(
    .DEPTH (SECTORS),
    .AW    (AW)
  ) u_ram (
    .clk_i      (clk_i),
    .wr_en_i    (wr_en),
    .wr_addr_i  (idx_q),
    .wr_entry_i (wr_entry),
    .rd_addr_i  (rd_addr),
    .rd_entry_o (rd_entry)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_INIT;
      idx_q         <= '0;
      cmd_q         <= CMD_CREATE;
      fid_q         <= '0;
      want_q        <= '0;
      granted_q     <= '0;
      status_q      <= ST_OK;
      free_q        <= CW'(SECTORS - RESERVED);
      file_valid_q  <= '0;
      out_valid_q   <= 1'b0;
      status_out_q  <= ST_OK;
      granted_out_q <= '0;
      free_out_q    <= '0;
    end else begin
      if (out_valid_q && !out_stall_i && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_INIT: begin
          if (last_idx) begin
            idx_q   <= '0;
            state_q <= S_IDLE;
          end else begin
            idx_q <= idx_q + AW'(1);
          end
        end
        S_IDLE: begin
          if (in_accept) begin
            cmd_q     <= cmd_i;
            fid_q     <= fid_in;
            want_q    <= sector_count_i;
            granted_q <= '0;
            idx_q     <= '0;
            if ((cmd_i == CMD_CREATE) && file_valid_q[fidx_in]) begin
              status_q <= ST_EXISTS;
              state_q  <= S_DONE;
            end else if ((cmd_i == CMD_CREATE) &&
                         (CMP_W'(sector_count_i) > CMP_W'(free_q))) begin
              status_q <= ST_NO_SPACE;
              state_q  <= S_DONE;
            end else if ((cmd_i == CMD_DELETE) && !file_valid_q[fidx_in]) begin
              status_q <= ST_NOT_FOUND;
              state_q  <= S_DONE;
            end else begin
              status_q <= ST_OK;
              state_q  <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (claim || free_hit) begin
            granted_q <= granted_q + CW'(1);
          end
          if (last_idx) begin
            idx_q   <= '0;
            state_q <= S_FIN;
          end else begin
            idx_q <= idx_q + AW'(1);
          end
        end
        S_FIN: begin
          if (cmd_q == CMD_CREATE) begin
            free_q               <= free_q - granted_q;
            file_valid_q[fidx_q] <= 1'b1;
          end else begin
            free_q               <= free_q + granted_q;
            file_valid_q[fidx_q] <= 1'b0;
          end
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_q   <= 1'b1;
            status_out_q  <= status_q;
            granted_out_q <= COUNT_W'(granted_q);
            free_out_q    <= COUNT_W'(free_q);
            state_q       <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o      = (state_q != S_IDLE);
  assign out_valid_o     = out_valid_q;
  assign status_o        = status_out_q;
  assign granted_count_o = granted_out_q;
  assign free_count_o    = free_out_q;

  `BSA_ASSERT_NOW(a_free_bound, 1'b1, 32'(free_q) <= SECTORS - RESERVED,
                  "free count too large")
  `BSA_ASSERT_NEXT(a_accept_busy, in_valid_i && !in_stall_o, in_stall_o,
                   "beat taken while busy")
  `BSA_ASSERT_NOW(a_create_exact, state_q == S_FIN && cmd_q == CMD_CREATE,
                  CMP_W'(granted_q) == CMP_W'(want_q), "create granted wrong count")
  `BSA_ASSERT_NEXT(a_done_hands_off, state_q == S_DONE && out_free,
                   out_valid_q && state_q == S_IDLE, "result not handed off")

endmodule
